[hdl/cholesky_factor_3x3_unit_macros.svh]
// Assertion macros for the 3x3 Cholesky factor unit checker
`ifndef CHOLESKY_FACTOR_3X3_UNIT_MACROS_SVH
`define CHOLESKY_FACTOR_3X3_UNIT_MACROS_SVH

// implication checked on the same edge, disabled during reset
`define CFS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// implication checked on the following edge, active through reset
`define CFS_ASSERT_NEXT(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cfs_pkg.sv]
// Package: word types, status codes and fixed widths for the Cholesky factor unit
`default_nettype none
package cfs_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // divider geometry: 64-bit magnitude, 31-bit divisor, 31 quotient bits
  localparam int DIV_MAG_W = 64;
  localparam int DIV_DEN_W = 31;
  localparam int DIV_Q_W   = 31;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_PIVOT  = 2'd1;
  localparam logic [1:0] ST_RADNEG = 2'd2;

  // register decode on paddr[2]
  localparam logic CFG_IDX_MIN_PIVOT = 1'b0;
  localparam logic [30:0] MIN_PIVOT_RST = 31'd1;

  typedef struct packed {
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a02;
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a22;
  } in_word_t;

  typedef struct packed {
    logic [30:0]        u00;
    logic signed [31:0] u01;
    logic signed [31:0] u02;
    logic [30:0]        u11;
    logic signed [31:0] u12;
    logic [30:0]        u22;
    logic [1:0]         status;
  } out_word_t;

endpackage
`default_nettype wire

[hdl/cholesky_factor_3x3_unit.sv]
// Top level: pipelined Cholesky factorisation of a symmetric 3x3 fixed-point matrix
//
// Input channel: drive start high with in_word (six upper-triangle entries, signed
// fixed point with FRAC_BITS fraction bits) for one cycle; the word is taken at that
// edge. busy stays low, so a new word may be offered on every cycle.
// Result channel: out_strobe is high for exactly one cycle with out_word holding
// u00..u22 and status (ok, pivot failure with all entries zero, or negative last
// radicand with u22 zero). Results leave in the order words arrived.
// Pipeline: three square-root pipelines (one root bit per stage) and two divider passes
// (one quotient bit per stage plus setup and saturation), the first pass holding two
// dividers side by side. Throughput: one word per cycle.
// Configuration: APB register min_pivot at address 0, reset value 1; write it only
// while no word is in flight.
// Reset (rst_n low, synchronous) clears every valid bit; nothing from before reset
// emerges. The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module cholesky_factor_3x3_unit import cfs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_word_t    in_word,
  output logic             out_strobe,
  output out_word_t        out_word,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int PW  = 32 + FRAC_BITS;
  localparam int SXW = PW - 1;
  localparam int RW  = (SXW + 1) / 2;

  typedef struct packed {
    logic signed [31:0] a01;
    logic signed [31:0] a02;
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a22;
    logic               fail;
  } sb1_t;

  typedef struct packed {
    logic [30:0]        u00;
    logic signed [31:0] a11;
    logic               fail;
  } sba_t;

  typedef struct packed {
    logic signed [31:0] a12;
    logic signed [31:0] a22;
  } sbb_t;

  typedef struct packed {
    logic [30:0]        u00;
    logic signed [31:0] u01;
    logic signed [31:0] u02;
    logic signed [63:0] u02sq;
    logic signed [31:0] a22;
    logic [63:0]        mag12;
    logic               neg12;
    logic               fail;
  } sb2_t;

  typedef struct packed {
    logic [30:0]        u00;
    logic signed [31:0] u01;
    logic signed [31:0] u02;
    logic [30:0]        u11;
    logic signed [63:0] u02sq;
    logic signed [31:0] a22;
    logic               fail;
  } sb3_t;

  typedef struct packed {
    logic [30:0]        u00;
    logic signed [31:0] u01;
    logic signed [31:0] u02;
    logic [30:0]        u11;
    logic signed [31:0] u12;
    logic               radneg;
    logic               fail;
  } sb4_t;

  // entry scaled by one, sign-extended to 64 bits
  function automatic logic signed [63:0] scale64(input logic signed [31:0] a);
    return {{(64 - PW){a[31]}}, a, {FRAC_BITS{1'b0}}};
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic pivot_ok(input logic [30:0] p, input logic [30:0] lim);
    return (p != '0) && (p >= lim);
  endfunction

  // configuration register
  logic [30:0] min_pivot_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_MIN_PIVOT);
  assign prdata = (paddr[2] == CFG_IDX_MIN_PIVOT) ? {1'b0, min_pivot_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pivot_r <= MIN_PIVOT_RST;
    end else if (cfg_wr) begin
      min_pivot_r <= pwdata[30:0];
    end
  end

  assign busy = 1'b0;

  // input register
  logic     p0_v_r;
  in_word_t p0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
    end else begin
      p0_v_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    p0_r <= in_word;
  end

  // first root: sqrt(a00 * one)
  logic [SXW-1:0] s1_x;
  sb1_t           s1_in, s1_out;
  logic           s1_v;
  logic [RW-1:0]  s1_root;

  assign s1_x  = p0_r.a00[31] ? '0 : {p0_r.a00[30:0], {FRAC_BITS{1'b0}}};
  assign s1_in = '{a01: p0_r.a01, a02: p0_r.a02, a11: p0_r.a11, a12: p0_r.a12,
                   a22: p0_r.a22, fail: p0_r.a00[31]};

  cfs_sqrt_pipe #(.XW(SXW), .SBW($bits(sb1_t))) u_sqrt0 (
    .clk, .rst_n,
    .in_valid(p0_v_r), .in_x(s1_x), .in_side(s1_in),
    .out_valid(s1_v), .out_root(s1_root), .out_side(s1_out)
  );

  // pivot check and divider setup for u01, u02
  logic [30:0] u00_w;
  logic        p1_v_r;
  logic [63:0] p1_maga_r, p1_magb_r;
  logic        p1_nega_r, p1_negb_r;
  logic [30:0] p1_den_r;
  sba_t        p1_sba_r;
  sbb_t        p1_sbb_r;

  assign u00_w = 31'(s1_root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else begin
      p1_v_r <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    p1_maga_r <= abs64(scale64(s1_out.a01));
    p1_nega_r <= s1_out.a01[31];
    p1_magb_r <= abs64(scale64(s1_out.a02));
    p1_negb_r <= s1_out.a02[31];
    p1_den_r  <= u00_w;
    p1_sba_r  <= '{u00: u00_w, a11: s1_out.a11,
                   fail: s1_out.fail || !pivot_ok(u00_w, min_pivot_r)};
    p1_sbb_r  <= '{a12: s1_out.a12, a22: s1_out.a22};
  end

  logic               da_v, db_v;
  logic signed [31:0] da_q, db_q;
  sba_t               da_sb;
  sbb_t               db_sb;

  cfs_div_pipe #(.SBW($bits(sba_t))) u_div01 (
    .clk, .rst_n,
    .in_valid(p1_v_r), .in_mag(p1_maga_r), .in_neg(p1_nega_r), .in_den(p1_den_r),
    .in_side(p1_sba_r),
    .out_valid(da_v), .out_q(da_q), .out_side(da_sb)
  );

  cfs_div_pipe #(.SBW($bits(sbb_t))) u_div02 (
    .clk, .rst_n,
    .in_valid(p1_v_r), .in_mag(p1_magb_r), .in_neg(p1_negb_r), .in_den(p1_den_r),
    .in_side(p1_sbb_r),
    .out_valid(db_v), .out_q(db_q), .out_side(db_sb)
  );

  // products of the first row
  logic               p2_v_r;
  logic signed [31:0] p2_u01_r, p2_u02_r;
  logic signed [63:0] p2_u01sq_r, p2_u0102_r, p2_u02sq_r;
  sba_t               p2_sba_r;
  sbb_t               p2_sbb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else begin
      p2_v_r <= da_v && db_v;
    end
  end

  always_ff @(posedge clk) begin
    p2_u01_r   <= da_q;
    p2_u02_r   <= db_q;
    p2_u01sq_r <= da_q * da_q;
    p2_u0102_r <= da_q * db_q;
    p2_u02sq_r <= db_q * db_q;
    p2_sba_r   <= da_sb;
    p2_sbb_r   <= db_sb;
  end

  // second radicand and u12 numerator
  logic signed [63:0] rad1_w, num12_w;
  logic               p3_v_r;
  logic [SXW-1:0]     p3_rad_r;
  sb2_t               p3_sb_r;

  assign rad1_w  = scale64(p2_sba_r.a11) - p2_u01sq_r;
  assign num12_w = scale64(p2_sbb_r.a12) - p2_u0102_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p3_rad_r <= rad1_w[63] ? '0 : rad1_w[SXW-1:0];
    p3_sb_r  <= '{u00: p2_sba_r.u00, u01: p2_u01_r, u02: p2_u02_r, u02sq: p2_u02sq_r,
                  a22: p2_sbb_r.a22, mag12: abs64(num12_w), neg12: num12_w[63],
                  fail: p2_sba_r.fail || rad1_w[63]};
  end

  logic          s2_v;
  logic [RW-1:0] s2_root;
  sb2_t          s2_out;

  cfs_sqrt_pipe #(.XW(SXW), .SBW($bits(sb2_t))) u_sqrt1 (
    .clk, .rst_n,
    .in_valid(p3_v_r), .in_x(p3_rad_r), .in_side(p3_sb_r),
    .out_valid(s2_v), .out_root(s2_root), .out_side(s2_out)
  );

  // second pivot check and divider setup for u12
  logic [30:0] u11_w;
  logic        p4_v_r;
  logic [63:0] p4_mag_r;
  logic        p4_neg_r;
  logic [30:0] p4_den_r;
  sb3_t        p4_sb_r;

  assign u11_w = 31'(s2_root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_v_r <= 1'b0;
    end else begin
      p4_v_r <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    p4_mag_r <= s2_out.mag12;
    p4_neg_r <= s2_out.neg12;
    p4_den_r <= u11_w;
    p4_sb_r  <= '{u00: s2_out.u00, u01: s2_out.u01, u02: s2_out.u02, u11: u11_w,
                  u02sq: s2_out.u02sq, a22: s2_out.a22,
                  fail: s2_out.fail || !pivot_ok(u11_w, min_pivot_r)};
  end

  logic               dc_v;
  logic signed [31:0] dc_q;
  sb3_t               dc_sb;

  cfs_div_pipe #(.SBW($bits(sb3_t))) u_div12 (
    .clk, .rst_n,
    .in_valid(p4_v_r), .in_mag(p4_mag_r), .in_neg(p4_neg_r), .in_den(p4_den_r),
    .in_side(p4_sb_r),
    .out_valid(dc_v), .out_q(dc_q), .out_side(dc_sb)
  );

  // u12 squared
  logic               p5_v_r;
  logic signed [31:0] p5_u12_r;
  logic signed [63:0] p5_u12sq_r;
  sb3_t               p5_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_v_r <= 1'b0;
    end else begin
      p5_v_r <= dc_v;
    end
  end

  always_ff @(posedge clk) begin
    p5_u12_r   <= dc_q;
    p5_u12sq_r <= dc_q * dc_q;
    p5_sb_r    <= dc_sb;
  end

  // last radicand
  logic [63:0]        sq_w;
  logic signed [63:0] rt_w;
  logic               radneg_w;
  logic               p6_v_r;
  logic [SXW-1:0]     p6_rad_r;
  sb4_t               p6_sb_r;

  assign sq_w     = $unsigned(p5_sb_r.u02sq) + $unsigned(p5_u12sq_r);
  assign rt_w     = scale64(p5_sb_r.a22);
  assign radneg_w = rt_w[63] || ($unsigned(rt_w) < sq_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_v_r <= 1'b0;
    end else begin
      p6_v_r <= p5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p6_rad_r <= radneg_w ? '0 : SXW'($unsigned(rt_w) - sq_w);
    p6_sb_r  <= '{u00: p5_sb_r.u00, u01: p5_sb_r.u01, u02: p5_sb_r.u02, u11: p5_sb_r.u11,
                  u12: p5_u12_r, radneg: radneg_w, fail: p5_sb_r.fail};
  end

  logic          s3_v;
  logic [RW-1:0] s3_root;
  sb4_t          s3_out;

  cfs_sqrt_pipe #(.XW(SXW), .SBW($bits(sb4_t))) u_sqrt2 (
    .clk, .rst_n,
    .in_valid(p6_v_r), .in_x(p6_rad_r), .in_side(p6_sb_r),
    .out_valid(s3_v), .out_root(s3_root), .out_side(s3_out)
  );

  // result word
  logic      out_v_r;
  out_word_t out_r, out_nxt;

  always_comb begin
    if (s3_out.fail) begin
      out_nxt        = '0;
      out_nxt.status = ST_PIVOT;
    end else begin
      out_nxt.u00    = s3_out.u00;
      out_nxt.u01    = s3_out.u01;
      out_nxt.u02    = s3_out.u02;
      out_nxt.u11    = s3_out.u11;
      out_nxt.u12    = s3_out.u12;
      out_nxt.u22    = s3_out.radneg ? '0 : 31'(s3_root);
      out_nxt.status = s3_out.radneg ? ST_RADNEG : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = out_v_r;
  assign out_word   = out_r;

endmodule
`default_nettype wire

[hdl/cfs_sqrt_pipe.sv]
// Pipelined floor integer square root, one root bit per stage
`default_nettype none
module cfs_sqrt_pipe #(
  parameter int XW  = 47,
  parameter int SBW = 1,
  localparam int RW = (XW + 1) / 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [XW-1:0]  in_x,
  input  wire logic [SBW-1:0] in_side,
  output logic                out_valid,
  output logic [RW-1:0]       out_root,
  output logic [SBW-1:0]      out_side
);

  localparam int XPW  = 2 * RW;
  localparam int REMW = RW + 2;

  logic [RW-1:0]   valid_r, valid_nxt;
  logic [XPW-1:0]  x_r    [RW];
  logic [XPW-1:0]  x_nxt  [RW];
  logic [REMW-1:0] rem_r  [RW];
  logic [REMW-1:0] rem_nxt[RW];
  logic [RW-1:0]   root_r [RW];
  logic [RW-1:0]   root_nxt[RW];
  logic [SBW-1:0]  sb_r   [RW];
  logic [SBW-1:0]  sb_nxt [RW];

  // one restoring step per stage
  always_comb begin
    logic [XPW-1:0]  xc;
    logic [REMW-1:0] rc;
    logic [RW-1:0]   oc;
    logic [REMW+1:0] cand;
    logic [REMW+1:0] trial;
    logic            take;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        xc           = XPW'(in_x);
        rc           = '0;
        oc           = '0;
        valid_nxt[k] = in_valid;
        sb_nxt[k]    = in_side;
      end else begin
        xc           = x_r[k-1];
        rc           = rem_r[k-1];
        oc           = root_r[k-1];
        valid_nxt[k] = valid_r[k-1];
        sb_nxt[k]    = sb_r[k-1];
      end
      cand        = {rc, xc[XPW-1 -: 2]};
      trial       = (REMW+2)'({oc, 2'b01});
      take        = (cand >= trial);
      x_nxt[k]    = xc << 2;
      rem_nxt[k]  = take ? REMW'(cand - trial) : REMW'(cand);
      root_nxt[k] = {oc[RW-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RW; k++) begin
      x_r[k]    <= x_nxt[k];
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      sb_r[k]   <= sb_nxt[k];
    end
  end

  assign out_valid = valid_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = sb_r[RW-1];

endmodule
`default_nettype wire

[hdl/cfs_div_pipe.sv]
// Pipelined signed-magnitude divider with saturation to 32 bits, one quotient bit per stage
`default_nettype none
module cfs_div_pipe import cfs_pkg::*; #(
  parameter int SBW = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic [DIV_MAG_W-1:0] in_mag,
  input  wire logic                 in_neg,
  input  wire logic [DIV_DEN_W-1:0] in_den,
  input  wire logic [SBW-1:0]       in_side,
  output logic                      out_valid,
  output logic signed [31:0]        out_q,
  output logic [SBW-1:0]            out_side
);

  localparam int NS = DIV_Q_W + 1;
  localparam int HW = DIV_MAG_W - DIV_Q_W;

  logic [NS-1:0]        valid_r, valid_nxt;
  logic [NS-1:0]        ovf_r, ovf_nxt;
  logic [NS-1:0]        neg_r, neg_nxt;
  logic [DIV_DEN_W-1:0] rem_r  [NS];
  logic [DIV_DEN_W-1:0] rem_nxt[NS];
  logic [DIV_Q_W-1:0]   low_r  [NS];
  logic [DIV_Q_W-1:0]   low_nxt[NS];
  logic [DIV_Q_W-1:0]   q_r    [NS];
  logic [DIV_Q_W-1:0]   q_nxt  [NS];
  logic [DIV_DEN_W-1:0] den_r  [NS];
  logic [DIV_DEN_W-1:0] den_nxt[NS];
  logic [SBW-1:0]       sb_r   [NS];
  logic [SBW-1:0]       sb_nxt [NS];

  logic                 out_v_r;
  logic signed [31:0]   out_q_r, out_q_nxt;
  logic [SBW-1:0]       out_sb_r;

  // stage 0 flags overflow, later stages shift in one quotient bit each
  always_comb begin
    logic [HW-1:0]        hi;
    logic [DIV_DEN_W:0]   cand;
    logic                 take;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        hi           = in_mag[DIV_MAG_W-1:DIV_Q_W];
        cand         = '0;
        take         = 1'b0;
        valid_nxt[k] = in_valid;
        ovf_nxt[k]   = (hi >= HW'(in_den));
        neg_nxt[k]   = in_neg;
        rem_nxt[k]   = ovf_nxt[k] ? '0 : DIV_DEN_W'(hi);
        low_nxt[k]   = in_mag[DIV_Q_W-1:0];
        q_nxt[k]     = '0;
        den_nxt[k]   = in_den;
        sb_nxt[k]    = in_side;
      end else begin
        hi           = '0;
        cand         = {rem_r[k-1], low_r[k-1][DIV_Q_W-1]};
        take         = (cand >= {1'b0, den_r[k-1]});
        valid_nxt[k] = valid_r[k-1];
        ovf_nxt[k]   = ovf_r[k-1];
        neg_nxt[k]   = neg_r[k-1];
        rem_nxt[k]   = take ? DIV_DEN_W'(cand - {1'b0, den_r[k-1]}) : DIV_DEN_W'(cand);
        low_nxt[k]   = low_r[k-1] << 1;
        q_nxt[k]     = {q_r[k-1][DIV_Q_W-2:0], take};
        den_nxt[k]   = den_r[k-1];
        sb_nxt[k]    = sb_r[k-1];
      end
    end
  end

  // sign and saturation
  always_comb begin
    if (ovf_r[NS-1]) begin
      out_q_nxt = neg_r[NS-1] ? Q_MIN : Q_MAX;
    end else if (neg_r[NS-1]) begin
      out_q_nxt = -$signed({1'b0, q_r[NS-1]});
    end else begin
      out_q_nxt = $signed({1'b0, q_r[NS-1]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      out_v_r <= valid_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    ovf_r <= ovf_nxt;
    neg_r <= neg_nxt;
    for (int k = 0; k < NS; k++) begin
      rem_r[k] <= rem_nxt[k];
      low_r[k] <= low_nxt[k];
      q_r[k]   <= q_nxt[k];
      den_r[k] <= den_nxt[k];
      sb_r[k]  <= sb_nxt[k];
    end
    out_q_r  <= out_q_nxt;
    out_sb_r <= sb_r[NS-1];
  end

  assign out_valid = out_v_r;
  assign out_q     = out_q_r;
  assign out_side  = out_sb_r;

endmodule
`default_nettype wire

[hdl/cfs_checker.sv]
// Port-level checker for the Cholesky factor unit, bound to the top level
`default_nettype none
`include "cholesky_factor_3x3_unit_macros.svh"
module cfs_checker import cfs_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_strobe,
  input wire out_word_t out_word
);

  `CFS_ASSERT_IMP(a_status_code, clk, rst_n, out_strobe, (out_word.status == ST_OK) || (out_word.status == ST_PIVOT) || (out_word.status == ST_RADNEG), "undefined status code")
  `CFS_ASSERT_IMP(a_pivot_zero, clk, rst_n, out_strobe && (out_word.status == ST_PIVOT), (out_word.u00 == '0) && (out_word.u01 == '0) && (out_word.u02 == '0) && (out_word.u11 == '0) && (out_word.u12 == '0) && (out_word.u22 == '0), "pivot failure word not cleared")
  `CFS_ASSERT_IMP(a_radneg_u22, clk, rst_n, out_strobe && (out_word.status == ST_RADNEG), out_word.u22 == '0, "u22 not zero on negative radicand")
  `CFS_ASSERT_IMP(a_ok_pivots, clk, rst_n, out_strobe && (out_word.status != ST_PIVOT), (out_word.u00 != '0) && (out_word.u11 != '0), "zero pivot in accepted word")
  `CFS_ASSERT_NEXT(a_reset_quiet, clk, !rst_n, !out_strobe, "result strobe right after reset")

endmodule

bind cholesky_factor_3x3_unit cfs_checker u_cfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_strobe (out_strobe),
  .out_word   (out_word)
);
`default_nettype wire
